// ----- rtl/core/uvs_pkg.sv -----
// ----------------------------------------------------------------------------
// uvs_pkg: shared types and constants for the UUID v5 generator
// SHA-1 initial values, round constants, and control structs between modules.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [63:0] VER_MASK = 64'hFFFFFFFFFFFF0FFF;
  localparam logic [63:0] VER_BITS = 64'h0000000000005000;
  localparam logic [63:0] VAR_MASK = 64'h3FFFFFFFFFFFFFFF;
  localparam logic [63:0] VAR_BITS = 64'h8000000000000000;

  // configuration register indexes
  localparam logic CFG_NS_HIGH = 1'b0;
  localparam logic CFG_NS_LOW  = 1'b1;

  localparam int unsigned ROUNDS = 80;

  // how the block word stream is formed during one compression
  typedef struct packed {
    logic         ns_block;  // bytes 0..15 come from the namespace
    logic         pad;       // 0x80 marker at byte valid_bytes
    logic         len;       // words 14 and 15 carry the bit length
    logic [6:0]   valid_bytes;
    logic [127:0] ns;
    logic [63:0]  bit_len;
  } fmt_t;

  typedef struct packed {
    logic       load;   // copy chain into round vars
    logic       step;   // run one round
    logic [6:0] cnt;    // round number
  } rnd_ctl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

// ----- rtl/core/uuid_v5_sha1_generator_core.sv -----
// ----------------------------------------------------------------------------
// uuid_v5_sha1_generator_core: name-based UUID version 5 generator
// Streams name bytes, hashes namespace plus name with SHA-1, emits the UUID.
// ----------------------------------------------------------------------------
// A name byte is taken only while the core is idle. Each time 64 message bytes have
// gathered, the block is compressed (one RAM read, 80 rounds on the shared round
// unit, one chain add), during which no item is taken. An item with tlast costs one
// more compression (two when 56 or more bytes sit in the last block) and then loads
// the result register; the next name may start while the result waits. The
// namespace registers act on the current name until its first byte arrives.
module uuid_v5_sha1_generator_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // name_byte
  input  logic         s_tuser,   // byte_present
  input  logic         s_tlast,   // last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // uuid_high [63:0], uuid_low [127:64]
);
  import uvs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [1:0] J_FULL = 2'd0;  // full data block
  localparam logic [1:0] J_PAD1 = 2'd1;  // pad and length in one block
  localparam logic [1:0] J_PADA = 2'd2;  // pad, length follows
  localparam logic [1:0] J_PADB = 2'd3;  // length-only block

  logic [2:0]   state;
  logic [1:0]   job;
  logic [6:0]   cnt;
  logic         pend_last;
  logic [63:0]  ns_high, ns_low;
  logic [127:0] ns_cur;
  logic         started;
  logic         first_blk;
  logic [6:0]   fill;
  logic [63:0]  msg_bytes;
  logic [31:0]  h0, h1, h2, h3, h4;

  logic         acc;
  logic [6:0]   fill_inc;
  logic [6:0]   fill_now;
  fmt_t         fmt;
  rnd_ctl_t     rctl;
  logic [31:0]  msg_word;
  logic [159:0] vars;
  logic [3:0]   rd_addr;
  logic [63:0]  hi_out, lo_out;

  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign fill_inc = fill + 7'd1;
  assign fill_now = s_tuser ? fill_inc : fill;

  always_comb begin
    fmt.ns_block = first_blk;
    fmt.pad      = (job != J_FULL) && (job != J_PADB);
    fmt.len      = (job == J_PAD1) || (job == J_PADB);
    unique case (job)
      J_FULL:  fmt.valid_bytes = 7'd64;
      J_PADB:  fmt.valid_bytes = 7'd0;
      default: fmt.valid_bytes = fill;
    endcase
    fmt.ns      = started ? ns_cur : {ns_high, ns_low};
    fmt.bit_len = {msg_bytes[60:0], 3'b000};
  end

  assign rctl.load = (state == S_RD);
  assign rctl.step = (state == S_RND);
  assign rctl.cnt  = cnt;
  assign rd_addr   = (state == S_RND) ? cnt[3:0] + 4'd1 : 4'd0;

  uvs_blkmem u_mem (
    .clk      (clk),
    .wr_en    (acc && s_tuser),
    .wr_pos   (fill[5:0]),
    .wr_byte  (s_tdata),
    .rd_addr  (rd_addr),
    .word_idx (cnt[3:0]),
    .fmt      (fmt),
    .word     (msg_word)
  );

  uvs_round u_rnd (
    .clk      (clk),
    .ctl      (rctl),
    .chain    ({h0, h1, h2, h3, h4}),
    .msg_word (msg_word),
    .vars     (vars)
  );

  assign hi_out = ({h0, h1} & VER_MASK) | VER_BITS;
  assign lo_out = ({h2, h3} & VAR_MASK) | VAR_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job       <= J_FULL;
      cnt       <= '0;
      pend_last <= 1'b0;
      ns_high   <= '0;
      ns_low    <= '0;
      started   <= 1'b0;
      first_blk <= 1'b1;
      fill      <= 7'd16;
      msg_bytes <= 64'd16;
      {h0, h1, h2, h3, h4} <= {IV0, IV1, IV2, IV3, IV4};
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_NS_HIGH) ns_high <= cfg_data;
        else if (cfg_addr == CFG_NS_LOW) ns_low <= cfg_data;
      end
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (s_tuser) begin
              fill      <= fill_inc;
              msg_bytes <= msg_bytes + 64'd1;
              started   <= 1'b1;
              if (!started) ns_cur <= {ns_high, ns_low};
            end
            if (s_tuser && fill_inc == 7'd64) begin
              job       <= J_FULL;
              pend_last <= s_tlast;
              state     <= S_RD;
            end else if (s_tlast) begin
              job   <= (fill_now < 7'd56) ? J_PAD1 : J_PADA;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          cnt   <= '0;
          state <= S_RND;
        end
        S_RND: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'(ROUNDS - 1)) state <= S_ADD;
        end
        S_ADD: begin
          h0 <= h0 + vars[159:128];
          h1 <= h1 + vars[127:96];
          h2 <= h2 + vars[95:64];
          h3 <= h3 + vars[63:32];
          h4 <= h4 + vars[31:0];
          first_blk <= 1'b0;
          unique case (job)
            J_FULL: begin
              fill <= '0;
              if (pend_last) begin
                pend_last <= 1'b0;
                job       <= J_PAD1;
                state     <= S_RD;
              end else begin
                state <= S_IDLE;
              end
            end
            J_PADA: begin
              job   <= J_PADB;
              state <= S_RD;
            end
            default: state <= S_OUT;
          endcase
        end
        S_OUT: begin
          // a held result leaves in this cycle, so a new one may replace it
          if (!m_tvalid || m_tready) begin
            m_tdata   <= {lo_out, hi_out};
            m_tvalid  <= 1'b1;
            started   <= 1'b0;
            first_blk <= 1'b1;
            fill      <= 7'd16;
            msg_bytes <= 64'd16;
            {h0, h1, h2, h3, h4} <= {IV0, IV1, IV2, IV3, IV4};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/uvs_blkmem.sv -----
// ----------------------------------------------------------------------------
// uvs_blkmem: block buffer memory and message word formatter
// Packs name bytes into a 16x32 word RAM and forms padded message words.
// ----------------------------------------------------------------------------
module uvs_blkmem (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [5:0]         wr_pos,
  input  logic [7:0]         wr_byte,
  input  logic [3:0]         rd_addr,
  input  logic [3:0]         word_idx,
  input  uvs_pkg::fmt_t      fmt,
  output logic [31:0]        word
);
  import uvs_pkg::*;

  logic [31:0] mem [16];
  logic [31:0] rdata;
  logic [31:0] wacc;
  logic [31:0] wacc_next;

  // the whole word is rewritten per byte; stale lanes are masked at read
  always_comb begin
    wacc_next = wacc;
    unique case (wr_pos[1:0])
      2'd0: wacc_next[31:24] = wr_byte;
      2'd1: wacc_next[23:16] = wr_byte;
      2'd2: wacc_next[15:8]  = wr_byte;
      default: wacc_next[7:0] = wr_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wacc <= wacc_next;
      mem[wr_pos[5:2]] <= wacc_next;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    logic [5:0] p;
    logic [7:0] b;
    word = '0;
    for (int j = 0; j < 4; j++) begin
      p = {word_idx, 2'(j)};
      if (fmt.ns_block && word_idx < 4'd4)
        b = fmt.ns[7'(127 - 8 * int'(p[3:0])) -: 8];
      else
        b = rdata[31 - 8 * j -: 8];
      if ({1'b0, p} < fmt.valid_bytes)
        word[31 - 8 * j -: 8] = b;
      else if (fmt.pad && {1'b0, p} == fmt.valid_bytes)
        word[31 - 8 * j -: 8] = 8'h80;
      else
        word[31 - 8 * j -: 8] = 8'h00;
    end
    if (fmt.len && word_idx == 4'd14) word = fmt.bit_len[63:32];
    if (fmt.len && word_idx == 4'd15) word = fmt.bit_len[31:0];
  end

endmodule

// ----- rtl/core/uvs_round.sv -----
// ----------------------------------------------------------------------------
// uvs_round: SHA-1 round datapath
// Working variables a..e and the 16-word schedule line, one round per cycle.
// ----------------------------------------------------------------------------
module uvs_round (
  input  logic                clk,
  input  uvs_pkg::rnd_ctl_t   ctl,
  input  logic [159:0]        chain,
  input  logic [31:0]         msg_word,
  output logic [159:0]        vars
);
  import uvs_pkg::*;

  logic [31:0] a, b, c, d, e;
  logic [31:0] sched [16];
  logic [31:0] w, f, k, tmp;

  always_comb begin
    if (ctl.cnt < 7'd16)
      w = msg_word;
    else
      w = rotl(sched[13] ^ sched[8] ^ sched[2] ^ sched[0], 1);
    if (ctl.cnt < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (ctl.cnt < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (ctl.cnt < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    tmp = rotl(a, 5) + f + e + w + k;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      {a, b, c, d, e} <= chain;
    end else if (ctl.step) begin
      e <= d;
      d <= c;
      c <= rotl(b, 30);
      b <= a;
      a <= tmp;
      for (int i = 0; i < 15; i++) sched[i] <= sched[i + 1];
      sched[15] <= w;
    end
  end

  assign vars = {a, b, c, d, e};

endmodule
